FILE: rtl/ptrb_pkg.sv
`default_nettype none
package ptrb_pkg;

  // Field and datapath widths
  localparam int unsigned PIX_W     = 16;
  localparam int unsigned COEF_W    = 40;
  localparam int unsigned COEF_N    = 5;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned OFF_W     = PIX_W + 1;      // signed pixel offset
  localparam int unsigned SQ_W      = 2 * PIX_W + 1;  // sum of two squares
  localparam int unsigned ROOT_W    = 17;             // floor sqrt of SQ_W bits
  localparam int unsigned ACC_W     = 48;             // polynomial accumulator
  localparam int unsigned QUO_W     = 33;             // quotient magnitude bits
  localparam int unsigned RAY_W     = 32;
  localparam int unsigned RAY_FRAC  = 24;
  localparam int unsigned POLY_SHL  = 12;             // 16 fraction bits -> 24 + ...

  // Pipeline latencies
  localparam int unsigned FRONT_LAT  = 3;
  localparam int unsigned SQRT_LAT   = ROOT_W;
  localparam int unsigned HORNER_LAT = 2 * (COEF_N - 1);
  localparam int unsigned DIV_LAT    = QUO_W + 3;
  localparam int unsigned TOTAL_LAT  = FRONT_LAT + SQRT_LAT + HORNER_LAT + DIV_LAT;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_U = 3'd0,
    CFG_CENTER_V = 3'd1,
    CFG_FOCAL    = 3'd2,
    CFG_COEF0    = 3'd3,
    CFG_COEF1    = 3'd4,
    CFG_COEF2    = 3'd5,
    CFG_COEF3    = 3'd6,
    CFG_COEF4    = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_u;
    logic [PIX_W-1:0] pixel_v;
  } pixel_t;

  typedef struct packed {
    logic signed [RAY_W-1:0] ray_x;
    logic signed [RAY_W-1:0] ray_y;
    logic signed [RAY_W-1:0] ray_z;
    logic                    clipped;
  } ray_t;

endpackage
`default_nettype wire

FILE: rtl/pixel_to_ray_poly_backproject.sv
`default_nettype none
// Pixel to ray back-projection for a radial polynomial camera model. Each beat
// carries one 12.4 pixel position and yields one ray beat (x, y, z with 24
// fraction bits, saturated, plus a clip flag). The block is a fixed pipeline of
// 64 stages: offset and squares (3), square root at one bit per stage (17),
// polynomial multiply/add pairs (8) and three parallel dividers by the focal
// scale at one quotient bit per stage (36). It takes one beat per clock when
// the output is not stalled; a stalled output freezes the whole pipeline.
// Registers are to be written only while no beat is in flight.
module pixel_to_ray_poly_backproject (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire ptrb_pkg::pixel_t                 in_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output ptrb_pkg::ray_t                        out_data_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [ptrb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [ptrb_pkg::COEF_W-1:0]      cfg_data_i
);
  import ptrb_pkg::*;

  localparam int unsigned DLY  = 2 + SQRT_LAT + HORNER_LAT;
  localparam int unsigned XN_W = OFF_W + RAY_FRAC;
  localparam int unsigned ZN_W = ACC_W + POLY_SHL;

  // configuration registers
  logic        [PIX_W-1:0]  center_u_q;
  logic        [PIX_W-1:0]  center_v_q;
  logic        [PIX_W-1:0]  focal_q;
  logic signed [COEF_W-1:0] coeff_q [COEF_N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_u_q <= '0;
      center_v_q <= '0;
      focal_q    <= PIX_W'(16);
      for (int i = 0; i < COEF_N; i++) coeff_q[i] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CENTER_U: center_u_q <= cfg_data_i[PIX_W-1:0];
        CFG_CENTER_V: center_v_q <= cfg_data_i[PIX_W-1:0];
        CFG_FOCAL:    focal_q    <= cfg_data_i[PIX_W-1:0];
        CFG_COEF0:    coeff_q[0] <= cfg_data_i;
        CFG_COEF1:    coeff_q[1] <= cfg_data_i;
        CFG_COEF2:    coeff_q[2] <= cfg_data_i;
        CFG_COEF3:    coeff_q[3] <= cfg_data_i;
        CFG_COEF4:    coeff_q[4] <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // zero focal scale acts as one
  logic [PIX_W-1:0] den;
  assign den = (focal_q == '0) ? PIX_W'(1) : focal_q;

  // global advance: hold everything while the output beat waits
  logic                 ce;
  logic [TOTAL_LAT-1:0] v_q;

  assign out_valid_o = v_q[TOTAL_LAT-1];
  assign in_stall_o  = out_valid_o && out_stall_i;
  assign ce          = !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (ce) begin
      v_q <= {v_q[TOTAL_LAT-2:0], in_valid_i};
    end
  end

  // front: offsets, squares, sum
  logic signed [OFF_W-1:0]   uu_q, vv_q;
  logic signed [2*OFF_W-1:0] squ, sqv;
  logic        [2*PIX_W-1:0] squ_q, sqv_q;
  logic        [SQ_W-1:0]    sum_q;

  assign squ = uu_q * uu_q;
  assign sqv = vv_q * vv_q;

  always_ff @(posedge clk_i) begin
    if (ce) begin
      uu_q  <= $signed({1'b0, in_data_i.pixel_u}) - $signed({1'b0, center_u_q});
      vv_q  <= $signed({1'b0, in_data_i.pixel_v}) - $signed({1'b0, center_v_q});
      squ_q <= squ[2*PIX_W-1:0];
      sqv_q <= sqv[2*PIX_W-1:0];
      sum_q <= {1'b0, squ_q} + {1'b0, sqv_q};
    end
  end

  // offsets ride alongside root and polynomial
  logic signed [OFF_W-1:0] uu_dly_q [DLY];
  logic signed [OFF_W-1:0] vv_dly_q [DLY];

  always_ff @(posedge clk_i) begin
    if (ce) begin
      uu_dly_q[0] <= uu_q;
      vv_dly_q[0] <= vv_q;
      for (int i = 1; i < DLY; i++) begin
        uu_dly_q[i] <= uu_dly_q[i-1];
        vv_dly_q[i] <= vv_dly_q[i-1];
      end
    end
  end

  logic        [ROOT_W-1:0] root;
  logic signed [ACC_W-1:0]  acc;

  ptrb_sqrt u_sqrt (
    .clk_i  (clk_i),
    .ce_i   (ce),
    .sq_i   (sum_q),
    .root_o (root)
  );

  ptrb_horner u_horner (
    .clk_i   (clk_i),
    .ce_i    (ce),
    .r_i     (root),
    .coeff_i (coeff_q),
    .acc_o   (acc)
  );

  // scaled numerators
  logic signed [XN_W-1:0] num_x, num_y;
  logic signed [ZN_W-1:0] num_z;
  logic signed [RAY_W-1:0] rx, ry, rz;
  logic                    cx, cy, cz;

  assign num_x = {uu_dly_q[DLY-1], {RAY_FRAC{1'b0}}};
  assign num_y = {vv_dly_q[DLY-1], {RAY_FRAC{1'b0}}};
  assign num_z = {acc, {POLY_SHL{1'b0}}};

  ptrb_div #(.NUM_W(XN_W)) u_div_x (
    .clk_i (clk_i), .ce_i (ce), .num_i (num_x), .den_i (den), .res_o (rx), .clip_o (cx)
  );

  ptrb_div #(.NUM_W(XN_W)) u_div_y (
    .clk_i (clk_i), .ce_i (ce), .num_i (num_y), .den_i (den), .res_o (ry), .clip_o (cy)
  );

  ptrb_div #(.NUM_W(ZN_W)) u_div_z (
    .clk_i (clk_i), .ce_i (ce), .num_i (num_z), .den_i (den), .res_o (rz), .clip_o (cz)
  );

  assign out_data_o.ray_x   = rx;
  assign out_data_o.ray_y   = ry;
  assign out_data_o.ray_z   = rz;
  assign out_data_o.clipped = cx | cy | cz;

  // checks
  a_stall_only_on_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled without a waiting output beat");

  a_freeze_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> (v_q == $past(v_q)))
    else $error("pipeline valid bits moved during a stall");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v_q[0])
    else $error("accepted beat did not enter the pipeline");

endmodule
`default_nettype wire

FILE: rtl/ptrb_sqrt.sv
`default_nettype none
// Pipelined digit-by-digit integer square root, one root bit per stage.
module ptrb_sqrt (
  input  wire logic                         clk_i,
  input  wire logic                         ce_i,
  input  wire logic [ptrb_pkg::SQ_W-1:0]    sq_i,
  output logic      [ptrb_pkg::ROOT_W-1:0]  root_o
);
  import ptrb_pkg::*;

  localparam int unsigned N_W   = 2 * ROOT_W;
  localparam int unsigned REM_W = ROOT_W + 2;
  localparam int unsigned TRY_W = REM_W + 2;

  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [N_W-1:0]    n_q    [ROOT_W];

  for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
    logic [REM_W-1:0]  rem_p;
    logic [ROOT_W-1:0] root_p;
    logic [N_W-1:0]    n_p;
    logic [TRY_W-1:0]  r4;
    logic [TRY_W-1:0]  trial;
    logic [TRY_W-1:0]  diff;
    logic              ge;

    if (g == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign n_p    = {{(N_W-SQ_W){1'b0}}, sq_i};
    end else begin : g_next
      assign rem_p  = rem_q[g-1];
      assign root_p = root_q[g-1];
      assign n_p    = n_q[g-1];
    end

    // bring in the next two bits, try root*4+1
    assign r4    = {rem_p, n_p[N_W-1 -: 2]};
    assign trial = {2'b00, root_p, 2'b01};
    assign ge    = (r4 >= trial);
    assign diff  = r4 - trial;

    always_ff @(posedge clk_i) begin
      if (ce_i) begin
        rem_q[g]  <= ge ? diff[REM_W-1:0] : r4[REM_W-1:0];
        root_q[g] <= {root_p[ROOT_W-2:0], ge};
        n_q[g]    <= {n_p[N_W-3:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[ROOT_W-1];

endmodule
`default_nettype wire

FILE: rtl/ptrb_horner.sv
`default_nettype none
// Horner evaluation of the radial polynomial: multiply stage, then add stage.
module ptrb_horner (
  input  wire logic                              clk_i,
  input  wire logic                              ce_i,
  input  wire logic        [ptrb_pkg::ROOT_W-1:0] r_i,
  input  wire logic signed [ptrb_pkg::COEF_W-1:0] coeff_i [ptrb_pkg::COEF_N],
  output logic signed      [ptrb_pkg::ACC_W-1:0]  acc_o
);
  import ptrb_pkg::*;

  localparam int unsigned STEPS = COEF_N - 1;
  localparam int unsigned MUL_W = ACC_W + ROOT_W + 1;
  localparam int unsigned SHR   = 16;

  logic signed [MUL_W-1:0]  mul_q [STEPS];
  logic        [ROOT_W-1:0] rm_q  [STEPS];
  logic signed [ACC_W-1:0]  acc_q [STEPS];
  logic        [ROOT_W-1:0] ra_q  [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic signed [ACC_W-1:0]  acc_p;
    logic        [ROOT_W-1:0] r_p;
    logic signed [ROOT_W:0]   r_s;
    logic signed [MUL_W-1:0]  prod;
    logic signed [COEF_W-1:0] c;
    logic signed [ACC_W-1:0]  c_ext;

    if (k == 0) begin : g_first
      assign acc_p = {{(ACC_W-COEF_W){coeff_i[COEF_N-1][COEF_W-1]}}, coeff_i[COEF_N-1]};
      assign r_p   = r_i;
    end else begin : g_next
      assign acc_p = acc_q[k-1];
      assign r_p   = ra_q[k-1];
    end

    assign r_s   = $signed({1'b0, r_p});
    assign prod  = acc_p * r_s;
    assign c     = coeff_i[COEF_N-2-k];
    assign c_ext = {{(ACC_W-COEF_W){c[COEF_W-1]}}, c};

    always_ff @(posedge clk_i) begin
      if (ce_i) begin
        mul_q[k] <= prod;
        rm_q[k]  <= r_p;
        // floor shift of the product, then add the next coefficient
        acc_q[k] <= c_ext + $signed(mul_q[k][ACC_W+SHR-1:SHR]);
        ra_q[k]  <= rm_q[k];
      end
    end
  end

  assign acc_o = acc_q[STEPS-1];

endmodule
`default_nettype wire

FILE: rtl/ptrb_div.sv
`default_nettype none
// Pipelined signed divide by the focal scale, truncating toward zero and
// saturating to 32 bits. Restoring division, one quotient bit per stage.
module ptrb_div #(
  parameter int unsigned NUM_W = 41
) (
  input  wire logic                               clk_i,
  input  wire logic                               ce_i,
  input  wire logic signed [NUM_W-1:0]            num_i,
  input  wire logic        [ptrb_pkg::PIX_W-1:0]  den_i,
  output logic signed      [ptrb_pkg::RAY_W-1:0]  res_o,
  output logic                                    clip_o
);
  import ptrb_pkg::*;

  localparam int unsigned HI_W = NUM_W - QUO_W;

  // magnitude stage
  logic             neg0_q;
  logic [NUM_W-1:0] mag_q;
  // overflow check stage
  logic             neg1_q;
  logic             ovf1_q;
  logic [PIX_W-1:0] rem1_q;
  logic [QUO_W-1:0] lo1_q;

  logic [HI_W+PIX_W-1:0] hi_ext;
  logic [HI_W+PIX_W-1:0] den_ext;

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      neg0_q <= num_i[NUM_W-1];
      mag_q  <= num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
    end
  end

  assign hi_ext  = {{PIX_W{1'b0}}, mag_q[NUM_W-1:QUO_W]};
  assign den_ext = {{HI_W{1'b0}}, den_i};

  // quotient needs more than QUO_W bits exactly when the high part reaches den
  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      neg1_q <= neg0_q;
      ovf1_q <= (hi_ext >= den_ext);
      rem1_q <= hi_ext[PIX_W-1:0];
      lo1_q  <= mag_q[QUO_W-1:0];
    end
  end

  logic [PIX_W-1:0] rem_q [QUO_W];
  logic [QUO_W-1:0] q_q   [QUO_W];
  logic [QUO_W-1:0] lo_q  [QUO_W];
  logic             neg_q [QUO_W];
  logic             ovf_q [QUO_W];

  for (genvar j = 0; j < QUO_W; j++) begin : g_bit
    logic [PIX_W-1:0] rem_p;
    logic [QUO_W-1:0] q_p;
    logic [QUO_W-1:0] lo_p;
    logic             neg_p;
    logic             ovf_p;
    logic [PIX_W:0]   r2;
    logic [PIX_W:0]   diff;
    logic             ge;

    if (j == 0) begin : g_first
      assign rem_p = rem1_q;
      assign q_p   = '0;
      assign lo_p  = lo1_q;
      assign neg_p = neg1_q;
      assign ovf_p = ovf1_q;
    end else begin : g_next
      assign rem_p = rem_q[j-1];
      assign q_p   = q_q[j-1];
      assign lo_p  = lo_q[j-1];
      assign neg_p = neg_q[j-1];
      assign ovf_p = ovf_q[j-1];
    end

    assign r2   = {rem_p, lo_p[QUO_W-1]};
    assign ge   = (r2 >= {1'b0, den_i});
    assign diff = r2 - {1'b0, den_i};

    always_ff @(posedge clk_i) begin
      if (ce_i) begin
        rem_q[j] <= ge ? diff[PIX_W-1:0] : r2[PIX_W-1:0];
        q_q[j]   <= {q_p[QUO_W-2:0], ge};
        lo_q[j]  <= {lo_p[QUO_W-2:0], 1'b0};
        neg_q[j] <= neg_p;
        ovf_q[j] <= ovf_p;
      end
    end
  end

  // sign and saturation
  logic [QUO_W-1:0] qf;
  logic             big;
  logic             negf;

  assign qf   = q_q[QUO_W-1];
  assign negf = neg_q[QUO_W-1];
  assign big  = ovf_q[QUO_W-1] || qf[QUO_W-1] ||
                (negf ? (qf[RAY_W-1] && (|qf[RAY_W-2:0])) : qf[RAY_W-1]);

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      clip_o <= big;
      if (big) begin
        res_o <= negf ? {1'b1, {(RAY_W-1){1'b0}}} : {1'b0, {(RAY_W-1){1'b1}}};
      end else begin
        res_o <= negf ? RAY_W'(-qf[RAY_W-1:0]) : qf[RAY_W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

FILE: sim/testbench.sv
`default_nettype none
module testbench;
  import ptrb_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  pixel_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  ray_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [COEF_W-1:0] cfg_data_i = '0;

  pixel_to_ray_poly_backproject dut (.*);

  always #1 clk_i = ~clk_i;

  // Shadow of the configuration registers
  logic [15:0] shadow_cu = 16'd0;
  logic [15:0] shadow_cv = 16'd0;
  logic [15:0] shadow_focal = 16'd16;
  logic signed [COEF_W-1:0] shadow_coef [COEF_N];

  ray_t expected_rays [$];
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  bit hold_off = 1'b0;
  bit failed = 1'b0;
  int unsigned cycle_count = 0;

  function automatic logic signed [31:0] clamp32(input logic signed [127:0] v, inout bit clip);
    if (v > 128'sd2147483647) begin
      clip = 1'b1;
      return 32'sh7fffffff;
    end else if (v < -128'sd2147483648) begin
      clip = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Back-project one pixel with the current register shadow
  function automatic ray_t backproject(input pixel_t px);
    logic signed [127:0] du, dv, fs, acc, prod, sq;
    logic [127:0] root;
    ray_t r;
    bit clip;
    clip = 1'b0;
    du = $signed({1'b0, px.pixel_u}) - $signed({1'b0, shadow_cu});
    dv = $signed({1'b0, px.pixel_v}) - $signed({1'b0, shadow_cv});
    fs = (shadow_focal == 16'd0) ? 128'sd1 : $signed({1'b0, shadow_focal});
    sq = du * du + dv * dv;
    // floor square root, bit by bit
    root = 0;
    for (int b = 17; b >= 0; b--) begin
      if ((root | (128'd1 << b)) * (root | (128'd1 << b)) <= sq) root |= 128'd1 << b;
    end
    acc = shadow_coef[4];
    for (int k = 3; k >= 0; k--) begin
      prod = acc * $signed(root);
      acc = shadow_coef[k] + (prod >>> 16);
    end
    r.ray_x = clamp32((du * 128'sd16777216) / fs, clip);
    r.ray_y = clamp32((dv * 128'sd16777216) / fs, clip);
    r.ray_z = clamp32((acc * 128'sd4096) / fs, clip);
    r.clipped = clip;
    return r;
  endfunction

  // Sender: one pixel beat, random idle first
  task automatic send_pixel(input pixel_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= px;
    expected_rays.push_back(backproject(px));
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_random(input int n, input bit near_center);
    pixel_t px;
    for (int i = 0; i < n; i++) begin
      px = pixel_t'($urandom());
      if (near_center && $urandom_range(1)) begin
        px.pixel_u = shadow_cu + 16'($urandom_range(0, 4000)) - 16'd2000;
        px.pixel_v = shadow_cv + 16'($urandom_range(0, 4000)) - 16'd2000;
      end
      send_pixel(px);
    end
  endtask

  // Receiver: random stall, or a long hold-off on request
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    out_stall_i <= hold_off || ($urandom_range(99) < stall_pct);
    if (cycle_count > LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    ray_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_rays.size() == 0) begin
        $error("unexpected ray beat %h", out_data_o);
        failed = 1'b1;
      end else begin
        want = expected_rays.pop_front();
        if (out_data_o.ray_x !== want.ray_x) begin
          $error("ray_x expected %0d got %0d", want.ray_x, out_data_o.ray_x); failed = 1'b1;
        end
        if (out_data_o.ray_y !== want.ray_y) begin
          $error("ray_y expected %0d got %0d", want.ray_y, out_data_o.ray_y); failed = 1'b1;
        end
        if (out_data_o.ray_z !== want.ray_z) begin
          $error("ray_z expected %0d got %0d", want.ray_z, out_data_o.ray_z); failed = 1'b1;
        end
        if (out_data_o.clipped !== want.clipped) begin
          $error("clipped expected %0b got %0b", want.clipped, out_data_o.clipped);
          failed = 1'b1;
        end
      end
    end
  end

  task automatic drain;
    in_valid_i <= 1'b0;
    while (expected_rays.size() != 0) @(posedge clk_i);
    repeat (TOTAL_LAT + 4) @(posedge clk_i);
  endtask

  // Register write; shadow follows the low bits the block keeps
  task automatic write_reg(input cfg_idx_e idx, input logic [COEF_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_CENTER_U: shadow_cu = val[15:0];
      CFG_CENTER_V: shadow_cv = val[15:0];
      CFG_FOCAL: shadow_focal = val[15:0];
      default: shadow_coef[idx - CFG_COEF0] = val;
    endcase
  endtask

  task automatic write_all(input logic [15:0] cu, input logic [15:0] cv,
                           input logic [15:0] fl, input logic [COEF_W-1:0] c0,
                           input logic [COEF_W-1:0] c1, input logic [COEF_W-1:0] c2,
                           input logic [COEF_W-1:0] c3, input logic [COEF_W-1:0] c4);
    drain();
    write_reg(CFG_CENTER_U, {24'($urandom()), cu});
    write_reg(CFG_CENTER_V, cv);
    write_reg(CFG_FOCAL, fl);
    write_reg(CFG_COEF0, c0);
    write_reg(CFG_COEF1, c1);
    write_reg(CFG_COEF2, c2);
    write_reg(CFG_COEF3, c3);
    write_reg(CFG_COEF4, c4);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [COEF_W-1:0] rand_coef();
    return {8'($urandom()), 32'($urandom())};
  endfunction

  // Field extremes, zero focal length and saturation
  task automatic test_directed;
    write_all(16'd8192, 16'd6000, 16'd0, 40'sd65536, -40'sd1000, 40'sd5, 40'sd0, -40'sd1);
    send_pixel('{16'd0, 16'd0});
    send_pixel('{16'hffff, 16'hffff});
    send_pixel('{16'd8192, 16'd6000});
    send_pixel('{16'hffff, 16'd0});
    write_all(16'hffff, 16'd0, 16'hffff, 40'h7f_ffff_ffff, 40'h7f_ffff_ffff,
              40'h7f_ffff_ffff, 40'h7f_ffff_ffff, 40'h7f_ffff_ffff);
    send_pixel('{16'd0, 16'd0});
    send_pixel('{16'hffff, 16'hffff});
    send_pixel('{16'h8000, 16'h7fff});
    write_all(16'd0, 16'hffff, 16'd1, 40'h80_0000_0000, 40'h80_0000_0000,
              40'h80_0000_0000, 40'h80_0000_0000, 40'h80_0000_0000);
    send_pixel('{16'd0, 16'd0});
    send_pixel('{16'hffff, 16'hffff});
    send_pixel('{16'd1, 16'hfffe});
    write_all(16'd100, 16'd100, 16'd16, 40'd0, 40'd0, 40'd0, 40'd0, 40'd0);
    send_pixel('{16'd100, 16'd100});
    send_pixel('{16'd101, 16'd99});
  endtask

  task automatic test_random_phases;
    for (int ph = 0; ph < 4; ph++) begin
      write_all(16'($urandom()), 16'($urandom()), 16'($urandom_range(1, 65535)),
                rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef());
      case (ph)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 82; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 82; end
        default: begin send_idle_pct = 23; stall_pct = 23; end
      endcase
      send_random(160, 1'b1);
    end
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  // Long receiver hold-off so the pipeline fills and back-pressures
  task automatic test_backpressure;
    write_all(16'($urandom()), 16'($urandom()), 16'd16, rand_coef() >>> 8, rand_coef() >>> 8,
              rand_coef() >>> 12, rand_coef() >>> 16, rand_coef() >>> 20);
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      send_random(100, 1'b0);
    join
  endtask

  initial begin
    for (int k = 0; k < COEF_N; k++) shadow_coef[k] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_phases();
    test_backpressure();
    drain();
    if (!failed) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: sim.f
rtl/ptrb_pkg.sv
rtl/ptrb_sqrt.sv
rtl/ptrb_horner.sv
rtl/ptrb_div.sv
rtl/pixel_to_ray_poly_backproject.sv
sim/testbench.sv
